// ===== src/rof_pkg.sv =====
// ============================================================================
// rof_pkg
// Shared types and constants for the radius outlier filter: field widths,
// operation and status codes, register indexes and the stored point record.
// ============================================================================
package rof_pkg;

    // Field widths
    localparam int COORD_W   = 32;
    localparam int IDX_W     = 12;
    localparam int CNT_W     = 12;
    localparam int RAD_W     = 20;
    localparam int MINN_W    = 12;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 112;
    localparam int M_DATA_W  = 112;

    // Store depth default
    localparam int MAX_POINTS_DEF = 4096;

    // Reset values of the configuration registers
    localparam logic [RAD_W-1:0]  RADIUS_RESET  = RAD_W'(3000);
    localparam logic [MINN_W-1:0] MIN_NBR_RESET = MINN_W'(15);

    // Neighbour count saturation
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EVAL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_NBR = 2'd1;

    // One stored point
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    // Candidate handed to the neighbour test
    typedef struct packed {
        logic                      vld;
        logic                      self_pt;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } cand_t;

    // Neighbour test status back to the sequencer
    typedef struct packed {
        logic busy;
        logic hit_vld;
        logic hit;
    } test_stat_t;

endpackage

// ===== src/radius_outlier_filter_unit.sv =====
// ============================================================================
// radius_outlier_filter_unit
// Radius outlier test over a stored 2-D point cloud.
// ============================================================================
// Usage:
//   Input words arrive on s_tvalid/s_tready; s_tuser carries the operation
//   (append, evaluate, clear) and s_tdata the point and index. Every input
//   word gives exactly one result word on m_tvalid/m_tready, with the status
//   in m_tuser and the point, neighbour count and keep flag in m_tdata.
//   radius and min_neighbors are set through cfg_valid/cfg_ready while idle.
// Timing:
//   Append, clear and failed evaluations go straight from idle to the output
//   state. An evaluation reads the reference point, then sweeps the store
//   one entry per cycle through the single read port, followed by a
//   four-stage distance pipeline that is drained before the result is loaded.
//   One word is worked on at a time; the next is accepted once the current
//   result sits in the output register, even if the sink has not taken it.
// Reset:
//   Store is emptied (count to zero), registers return to 3000 mm and 15.
//   Store contents are not cleared; only entries below the count are read.
// Stall:
//   While m_tready is low the result holds and a finished next result waits.
// ============================================================================
module radius_outlier_filter_unit #(
    parameter int MAX_POINTS = rof_pkg::MAX_POINTS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], point_index[107:96]
    input  logic [rof_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: mode[1:0]
    input  logic [rof_pkg::MODE_W-1:0]      s_tuser,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: out_x[31:0], out_y[63:32], out_z[95:64],
    //          neighbor_count[107:96], keep[108]
    output logic [rof_pkg::M_DATA_W-1:0]    m_tdata,
    // m_tuser: status[1:0]
    output logic [rof_pkg::STATUS_W-1:0]    m_tuser,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rof_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rof_pkg::RAD_W-1:0]       cfg_data
);
    import rof_pkg::*;

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_REF   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_SWEEP = 6'b001000,
        S_DRAIN = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [RAD_W-1:0]  radius_reg;
    logic [MINN_W-1:0] min_nbr_reg;

    // Store bookkeeping
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] k_reg, k_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // Read alignment with the store's registered data
    logic rd_vld_reg, rd_vld_next;
    logic rd_self_reg, rd_self_next;

    // Pending result
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                res_eval_reg, res_eval_next;
    point_t              ref_reg, ref_next;
    logic [CNT_W-1:0]    nbr_cnt_reg, nbr_cnt_next;

    // Output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [STATUS_W-1:0] m_status_reg;
    point_t              m_pt_reg;
    logic [CNT_W-1:0]    m_cnt_reg;
    logic                m_keep_reg;
    logic                out_load;

    // Store ports
    logic          mem_we;
    logic [AW-1:0] mem_raddr;
    point_t        mem_wdata;
    point_t        mem_rdata;

    // Test unit
    cand_t      cand;
    test_stat_t tstat;

    // Input decode
    logic [MODE_W-1:0] in_mode;
    logic [IDX_W-1:0]  in_idx;
    logic              in_accept;
    logic              store_full;
    logic              sweep_last;

    assign in_mode   = s_tuser;
    assign in_idx    = s_tdata[3*COORD_W +: IDX_W];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign mem_wdata.x = s_tdata[0 +: COORD_W];
    assign mem_wdata.y = s_tdata[COORD_W +: COORD_W];
    assign mem_wdata.z = s_tdata[2*COORD_W +: COORD_W];

    assign store_full = (count_reg == CW'(MAX_POINTS));
    assign sweep_last = ((CW'(k_reg) + CW'(1)) == count_reg);
    assign mem_raddr  = (state_reg == S_REF) ? AW'(idx_reg) : k_reg;
    assign out_load   = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    rof_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(count_reg)),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cand.vld     = rd_vld_reg;
    assign cand.self_pt = rd_self_reg;
    assign cand.x       = mem_rdata.x;
    assign cand.y       = mem_rdata.y;

    rof_nbr_test u_test (
        .aclk    (aclk),
        .aresetn (aresetn),
        .radius  (radius_reg),
        .ref_x   (ref_reg.x),
        .ref_y   (ref_reg.y),
        .cand    (cand),
        .stat    (tstat)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        rd_vld_next     = 1'b0;
        rd_self_next    = 1'b0;
        res_status_next = res_status_reg;
        res_eval_next   = res_eval_reg;
        ref_next        = ref_reg;
        nbr_cnt_next    = nbr_cnt_reg;
        mem_we          = 1'b0;

        // Count neighbours as verdicts leave the pipeline
        if (tstat.hit_vld && tstat.hit && (nbr_cnt_reg != COUNT_MAX)) begin
            nbr_cnt_next = nbr_cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    idx_next        = in_idx;
                    res_status_next = ST_OK;
                    res_eval_next   = 1'b0;
                    nbr_cnt_next    = '0;
                    state_next      = S_OUT;
                    case (in_mode)
                        MODE_APPEND: begin
                            if (store_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_EVAL: begin
                            if (CMPW'(in_idx) >= CMPW'(count_reg)) begin
                                res_status_next = ST_NOT_LOADED;
                            end else begin
                                state_next = S_REF;
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_REF: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                ref_next      = mem_rdata;
                res_eval_next = 1'b1;
                k_next        = '0;
                state_next    = S_SWEEP;
            end
            S_SWEEP: begin
                rd_vld_next  = 1'b1;
                rd_self_next = (CMPW'(k_reg) == CMPW'(idx_reg));
                if (sweep_last) begin
                    state_next = S_DRAIN;
                end else begin
                    k_next = k_reg + AW'(1);
                end
            end
            S_DRAIN: begin
                if (!rd_vld_reg && !tstat.busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output handshake
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            radius_reg   <= RADIUS_RESET;
            min_nbr_reg  <= MIN_NBR_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RADIUS:  radius_reg  <= cfg_data;
                    REG_MIN_NBR: min_nbr_reg <= cfg_data[MINN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        idx_reg        <= idx_next;
        rd_self_reg    <= rd_self_next;
        res_status_reg <= res_status_next;
        res_eval_reg   <= res_eval_next;
        ref_reg        <= ref_next;
        nbr_cnt_reg    <= nbr_cnt_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_pt_reg     <= res_eval_reg ? ref_reg : '0;
            m_cnt_reg    <= res_eval_reg ? nbr_cnt_reg : '0;
            m_keep_reg   <= res_eval_reg && (nbr_cnt_reg >= min_nbr_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_keep_reg, m_cnt_reg, m_pt_reg.z, m_pt_reg.y, m_pt_reg.x};

`ifndef ASSERT_OFF
    // Store count never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    // Writes only land on free entries
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !store_full)
        else $error("store write while full");

    // Sweep stays within loaded entries
    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SWEEP) |-> (CW'(k_reg) < count_reg))
        else $error("sweep address beyond loaded points");

    // A result only appears from the output state
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    // Nothing left in flight when a result is handed over
    a_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!rd_vld_reg && !tstat.busy))
        else $error("result handed over with test pipeline busy");
`endif

endmodule

// ===== src/rof_store.sv =====
// ============================================================================
// rof_store
// Point store: one write port, one read port with registered read data.
// ============================================================================
module rof_store #(
    parameter int DEPTH = rof_pkg::MAX_POINTS_DEF,
    parameter int AW    = $clog2(rof_pkg::MAX_POINTS_DEF)
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  rof_pkg::point_t wdata,
    input  logic [AW-1:0]   raddr,
    output rof_pkg::point_t rdata
);
    import rof_pkg::*;

    point_t mem [DEPTH];
    point_t rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rof_nbr_test.sv =====
// ============================================================================
// rof_nbr_test
// Four-stage neighbour test: offset, magnitude and box check, squares,
// sum against the squared radius. One candidate per cycle.
// ============================================================================
module rof_nbr_test (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [rof_pkg::RAD_W-1:0]           radius,
    input  logic signed [rof_pkg::COORD_W-1:0]  ref_x,
    input  logic signed [rof_pkg::COORD_W-1:0]  ref_y,
    input  rof_pkg::cand_t                      cand,
    output rof_pkg::test_stat_t                 stat
);
    import rof_pkg::*;

    localparam int DW = COORD_W + 1;
    localparam int SW = 2 * RAD_W;

    // Squared radius, refreshed every cycle from the register
    logic [SW-1:0] rsq_reg;

    // Stage 1: signed offsets
    logic                 vld1_reg;
    logic                 self1_reg;
    logic signed [DW-1:0] dx1_reg, dy1_reg;
    logic signed [DW-1:0] dx1_next, dy1_next;

    // Stage 2: magnitudes within the box
    logic             vld2_reg;
    logic             ok2_reg;
    logic [RAD_W-1:0] ax2_reg, ay2_reg;
    logic [DW-1:0]    mag_x, mag_y;
    logic             near_x, near_y;

    // Stage 3: squares
    logic          vld3_reg;
    logic          ok3_reg;
    logic [SW-1:0] sqx3_reg, sqy3_reg;

    // Stage 4: verdict
    logic            vld4_reg;
    logic            hit4_reg;
    logic [SW:0]     sum3;

    always_ff @(posedge aclk) begin
        rsq_reg <= SW'(radius) * SW'(radius);
    end

    // Offsets, sign-extended to avoid overflow
    assign dx1_next = {ref_x[COORD_W-1], ref_x} - {cand.x[COORD_W-1], cand.x};
    assign dy1_next = {ref_y[COORD_W-1], ref_y} - {cand.y[COORD_W-1], cand.y};

    // Magnitude and box check
    assign mag_x  = dx1_reg[DW-1] ? (~dx1_reg + DW'(1)) : dx1_reg;
    assign mag_y  = dy1_reg[DW-1] ? (~dy1_reg + DW'(1)) : dy1_reg;
    assign near_x = (mag_x <= DW'(radius));
    assign near_y = (mag_y <= DW'(radius));

    assign sum3 = {1'b0, sqx3_reg} + {1'b0, sqy3_reg};

    // Valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else begin
            vld1_reg <= cand.vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    // Data pipeline
    always_ff @(posedge aclk) begin
        self1_reg <= cand.self_pt;
        dx1_reg   <= dx1_next;
        dy1_reg   <= dy1_next;

        ok2_reg <= !self1_reg && near_x && near_y;
        ax2_reg <= mag_x[RAD_W-1:0];
        ay2_reg <= mag_y[RAD_W-1:0];

        ok3_reg  <= ok2_reg;
        sqx3_reg <= SW'(ax2_reg) * SW'(ax2_reg);
        sqy3_reg <= SW'(ay2_reg) * SW'(ay2_reg);

        hit4_reg <= ok3_reg && (sum3 <= {1'b0, rsq_reg});
    end

    assign stat.busy    = vld1_reg | vld2_reg | vld3_reg | vld4_reg;
    assign stat.hit_vld = vld4_reg;
    assign stat.hit     = hit4_reg;

endmodule

// ===== tb/sv/rof_checker.sv =====
// ============================================================================
// rof_checker
// Result predictor and scoreboard for the radius outlier filter.
// ============================================================================
// Watches the input, result and register write channels of the block. Every
// accepted input word is run through a local copy of the point store and the
// two registers, and the result it must give is queued. Every accepted result
// word is compared field by field with the oldest queued result. The failure
// count, the number of results still owed and the number checked go back to
// the testbench top.
// ============================================================================
module rof_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // s_tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], point_index[107:96]
    input  logic [rof_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: mode[1:0]
    input  logic [rof_pkg::MODE_W-1:0]      s_tuser,
    // Result stream
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: out_x[31:0], out_y[63:32], out_z[95:64],
    //          neighbor_count[107:96], keep[108]
    input  logic [rof_pkg::M_DATA_W-1:0]    m_tdata,
    // m_tuser: status[1:0]
    input  logic [rof_pkg::STATUS_W-1:0]    m_tuser,
    // Register writes
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rof_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rof_pkg::RAD_W-1:0]       cfg_data,
    // Back to the top
    output int                              mismatches,
    output int                              pending,
    output int                              checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rof_pkg::*;

    localparam int STORE_DEPTH = MAX_POINTS_DEF;
    localparam int REPORT_MAX  = 10;
    localparam int M_PAD_W     = M_DATA_W - 3 * COORD_W - CNT_W - 1;

    // One result word, split into its fields
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [CNT_W-1:0]    count;
        logic                keep;
        logic [M_PAD_W-1:0]  pad;
    } outcome_t;

    // Local copy of the block's state
    logic [COORD_W-1:0] store_x [STORE_DEPTH];
    logic [COORD_W-1:0] store_y [STORE_DEPTH];
    logic [COORD_W-1:0] store_z [STORE_DEPTH];
    int unsigned        points_held = 0;
    logic [RAD_W-1:0]   radius_q    = RADIUS_RESET;
    logic [MINN_W-1:0]  min_nbr_q   = MIN_NBR_RESET;

    outcome_t           expected_results [$];
    int                 fail_count      = 0;
    int                 results_checked = 0;

    // Other stored points with dx^2 + dy^2 <= r^2, saturating at the count max
    function automatic logic [CNT_W-1:0] count_neighbours(int unsigned ctr);
        longint      r;
        longint      dx;
        longint      dy;
        int unsigned n;
        int unsigned k;
        r = longint'(radius_q);
        n = 0;
        for (k = 0; k < points_held; k++) begin
            dx = longint'($signed(store_x[k])) - longint'($signed(store_x[ctr]));
            dy = longint'($signed(store_y[k])) - longint'($signed(store_y[ctr]));
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            // bound each offset first so the squares stay small
            if (k != ctr && dx <= r && dy <= r && dx * dx + dy * dy <= r * r
                && n < 32'(COUNT_MAX))
                n++;
        end
        return CNT_W'(n);
    endfunction

    // Apply one input word to the local store and give the result it owes
    function automatic outcome_t predict_result(logic [MODE_W-1:0] mode,
                                                logic [S_DATA_W-1:0] word);
        outcome_t    res;
        int unsigned ctr;
        res        = '0;
        res.status = ST_OK;
        ctr        = 32'(word[3*COORD_W +: IDX_W]);
        case (mode)
            MODE_APPEND: begin
                if (points_held >= STORE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    store_x[points_held] = word[0 +: COORD_W];
                    store_y[points_held] = word[COORD_W +: COORD_W];
                    store_z[points_held] = word[2*COORD_W +: COORD_W];
                    points_held++;
                end
            end
            MODE_EVAL: begin
                if (ctr >= points_held) begin
                    res.status = ST_NOT_LOADED;
                end else begin
                    res.x     = store_x[ctr];
                    res.y     = store_y[ctr];
                    res.z     = store_z[ctr];
                    res.count = count_neighbours(ctr);
                    res.keep  = (res.count >= min_nbr_q);
                end
            end
            MODE_CLEAR: points_held = 0;
            default: ;
        endcase
        return res;
    endfunction

    // One field of one result; only the first few failures are reported
    function automatic void check_field(string field, logic [COORD_W-1:0] want,
                                        logic [COORD_W-1:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: result %0d, %s: expected 0x%0h, got 0x%0h",
                         $time, results_checked, field, want, got);
        end
    endfunction

    // Per clock: register writes, then result words, then new input words
    always @(posedge aclk) begin : watch
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            points_held = 0;
            radius_q    = RADIUS_RESET;
            min_nbr_q   = MIN_NBR_RESET;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RADIUS:  radius_q  = cfg_data;
                    REG_MIN_NBR: min_nbr_q = cfg_data[MINN_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.x      = m_tdata[0 +: COORD_W];
                got.y      = m_tdata[COORD_W +: COORD_W];
                got.z      = m_tdata[2*COORD_W +: COORD_W];
                got.count  = m_tdata[3*COORD_W +: CNT_W];
                got.keep   = m_tdata[3*COORD_W + CNT_W];
                got.pad    = m_tdata[M_DATA_W-1 -: M_PAD_W];
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result word with none expected: status %0d, data 0x%0h",
                                 $time, got.status, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", COORD_W'(want.status), COORD_W'(got.status));
                    check_field("out_x", want.x, got.x);
                    check_field("out_y", want.y, got.y);
                    check_field("out_z", want.z, got.z);
                    check_field("neighbor_count", COORD_W'(want.count),
                                COORD_W'(got.count));
                    check_field("keep", COORD_W'(want.keep), COORD_W'(got.keep));
                    check_field("padding", COORD_W'(want.pad), COORD_W'(got.pad));
                    results_checked++;
                end
            end

            if (s_tvalid && s_tready)
                expected_results.push_back(predict_result(s_tuser, s_tdata));
        end
        mismatches <= fail_count;
        pending    <= expected_results.size();
        checked    <= results_checked;
    end

endmodule

// ===== tb/sv/tb_radius_outlier_filter_unit.sv =====
// ============================================================================
// tb_radius_outlier_filter_unit
// Stimulus and verdict for the radius outlier filter.
// ============================================================================
// Drives appends, evaluations, clears and unused-mode words into the block:
// a short directed set on the edges of the neighbour test, the widest radius
// with a zero threshold, and random clustered point sets under a range of
// radius and threshold settings. Both streams idle at random apart from one
// calm stretch. Checking is done by rof_checker; a watchdog ends the run if
// no word moves for too long.
// ============================================================================
module tb_radius_outlier_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rof_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
    localparam logic [RAD_W-1:0]     RADIUS_MAX  = '1;
    localparam logic [MINN_W-1:0]    MIN_NBR_MAX = '1;
    localparam logic [COORD_W-1:0]   COORD_MIN   = 32'h8000_0000;
    localparam logic [COORD_W-1:0]   COORD_MAX   = 32'h7FFF_FFFF;
    localparam int STORE_DEPTH  = MAX_POINTS_DEF;
    localparam int RANDOM_WORDS = 110;
    localparam int IDLE_PCT     = 11;
    localparam int QUIET_LIMIT  = 40000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [RAD_W-1:0]      cfg_data  = '0;

    int          chk_mismatches;
    int          chk_pending;
    int          chk_checked;

    bit          calm = 1'b0;   // no idling on either side while set
    int unsigned fill = 0;      // points held by the block, to steer indexes
    int          n_append   = 0;
    int          n_eval     = 0;
    int          n_clear    = 0;
    int          n_other    = 0;
    int          n_settings = 0;
    int          quiet      = 0;

    radius_outlier_filter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rof_checker u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (chk_mismatches),
        .pending    (chk_pending),
        .checked    (chk_checked)
    );

    // 250 MHz clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Result sink: random back-pressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog on cycles where no word moves on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results owed",
                     quiet, chk_pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // One input word; a random idle gap first unless in the calm stretch
    task automatic send_word(logic [MODE_W-1:0] mode, logic [COORD_W-1:0] px,
                             logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz,
                             logic [IDX_W-1:0] idx);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_DATA_W - 3*COORD_W - IDX_W){1'b0}}, idx, pz, py, px};
        do @(posedge aclk); while (!s_tready);
        case (mode)
            MODE_APPEND: begin
                n_append++;
                if (fill < STORE_DEPTH) fill++;
            end
            MODE_EVAL:  n_eval++;
            MODE_CLEAR: begin
                n_clear++;
                fill = 0;
            end
            default:    n_other++;
        endcase
    endtask

    // Wait until every word sent so far has had its result taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (chk_pending != 0);
    endtask

    // Write both registers while idle, optionally also the unused index
    task automatic set_registers(logic [RAD_W-1:0] rad, logic [MINN_W-1:0] minn,
                                 bit spare);
        logic [CFG_IDX_W-1:0] idx_list  [3];
        logic [RAD_W-1:0]     data_list [3];
        int                   n;
        int                   i;
        idx_list[0]  = REG_RADIUS;
        data_list[0] = rad;
        // upper bits carry noise, only the low 12 bits belong to the threshold
        idx_list[1]  = REG_MIN_NBR;
        data_list[1] = RAD_W'($urandom);
        data_list[1][MINN_W-1:0] = minn;
        idx_list[2]  = REG_SPARE;
        data_list[2] = RAD_W'($urandom);
        n = spare ? 3 : 2;
        wait_idle();
        for (i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[i];
            cfg_data  <= data_list[i];
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Well-formed run: optional clear, a cluster of appends, then evaluations,
    // with the odd broken or unused-mode word mixed in
    task automatic random_run(logic [RAD_W-1:0] rad);
        int unsigned        n_pts;
        int unsigned        span;
        int unsigned        i;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic [IDX_W-1:0]   idx;
        if (fill == 0 || $urandom_range(0, 9) < 6)
            send_word(MODE_CLEAR, $urandom, $urandom, $urandom, IDX_W'($urandom));
        if ($urandom_range(0, 4) == 0)
            send_word(MODE_EVAL, $urandom, $urandom, $urandom, IDX_W'($urandom));

        n_pts = $urandom_range(1, 12);
        span  = (rad < 4) ? 32'd3 : 32'(rad) + 32'(rad) / 2;
        cx    = $urandom;
        cy    = $urandom;
        for (i = 0; i < n_pts; i++) begin
            case ($urandom_range(0, 7))
                0: begin           // copy of the centre
                    px = cx;
                    py = cy;
                end
                1: begin           // exactly on the circle
                    px = cx + COORD_W'(rad);
                    py = cy;
                end
                2: begin           // stray point anywhere
                    px = $urandom;
                    py = $urandom;
                end
                default: begin
                    px = cx + ($urandom_range(0, 2 * span) - span);
                    py = cy + ($urandom_range(0, 2 * span) - span);
                end
            endcase
            send_word(MODE_APPEND, px, py, $urandom, IDX_W'($urandom));
        end

        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 99) < 85 || fill >= STORE_DEPTH)
                idx = IDX_W'($urandom_range(0, fill - 1));
            else
                idx = IDX_W'($urandom_range(fill, STORE_DEPTH - 1));
            send_word(MODE_EVAL, $urandom, $urandom, $urandom, idx);
        end

        if ($urandom_range(0, 4) == 0)
            send_word(MODE_UNUSED, $urandom, $urandom, $urandom, IDX_W'($urandom));
    endtask

    // Stimulus
    initial begin : stimulus
        int                 round;
        int                 base;
        logic [RAD_W-1:0]   rad;
        logic [MINN_W-1:0]  minn;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset settings: empty store, unused mode, circle edges,
        // extreme coordinates, indexes past the fill, clear
        send_word(MODE_EVAL, '0, '0, '0, '0);
        send_word(MODE_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, '1);
        send_word(MODE_APPEND, 32'd0, 32'd0, 32'd0, '0);
        send_word(MODE_APPEND, 32'd3000, 32'd0, 32'hFFFF_FFFF, '0);
        send_word(MODE_APPEND, 32'd2121, 32'd2121, 32'd1, '0);
        send_word(MODE_APPEND, 32'd2122, 32'd2122, 32'd0, '0);
        send_word(MODE_APPEND, COORD_MIN, COORD_MAX, COORD_MIN, '1);
        send_word(MODE_APPEND, COORD_MAX, COORD_MIN, COORD_MAX, '0);
        send_word(MODE_EVAL, '0, '0, '0, IDX_W'(0));
        send_word(MODE_EVAL, '0, '0, '0, IDX_W'(1));
        send_word(MODE_EVAL, '1, '1, '1, IDX_W'(4));
        send_word(MODE_EVAL, '0, '0, '0, IDX_W'(6));
        send_word(MODE_EVAL, '0, '0, '0, '1);
        send_word(MODE_CLEAR, '1, '1, '1, '1);
        send_word(MODE_EVAL, '0, '0, '0, '0);

        // Directed, largest radius and zero threshold
        set_registers(RADIUS_MAX, '0, 1'b1);
        send_word(MODE_APPEND, 32'd0, 32'd0, 32'd5, '0);
        send_word(MODE_APPEND, 32'd1048575, 32'd0, 32'd6, '0);
        send_word(MODE_APPEND, 32'd1048576, 32'd0, 32'd7, '0);
        send_word(MODE_APPEND, 32'd1048575, 32'd1048575, 32'd8, '0);
        send_word(MODE_EVAL, '0, '0, '0, IDX_W'(0));
        send_word(MODE_EVAL, '0, '0, '0, IDX_W'(3));

        // Random runs over a spread of register settings
        base  = n_append + n_eval + n_clear;
        round = 0;
        while (n_append + n_eval + n_clear - base < RANDOM_WORDS) begin
            case ($urandom_range(0, 4))
                0:       rad = '0;
                1:       rad = RAD_W'($urandom_range(1, 16));
                2:       rad = RAD_W'($urandom_range(100, 5000));
                3:       rad = RADIUS_MAX;
                default: rad = RAD_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0:       minn = '0;
                1:       minn = MINN_W'($urandom_range(1, 5));
                2:       minn = MINN_W'($urandom_range(1, 10));
                3:       minn = MIN_NBR_MAX;
                default: minn = MINN_W'($urandom);
            endcase
            set_registers(rad, minn, round % 4 == 1);
            calm = (round >= 3 && round < 6);
            repeat ($urandom_range(2, 4)) random_run(rad);
            round++;
        end
        calm = 1'b0;

        // Drain, then let any stray word show up
        wait_idle();
        repeat (16) @(posedge aclk);

        $display("covered %0d appends, %0d evaluations, %0d clears, %0d unused-mode words",
                 n_append, n_eval, n_clear, n_other);
        $display("%0d register settings from radius 0 to %0d mm; %0d results checked",
                 n_settings, RADIUS_MAX, chk_checked);
        if (chk_mismatches == 0 && chk_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
